FILE: rtl/two_stack_fifo_queue_defines.svh
// Assertion macros used by the two-stack queue top level.
`ifndef TWO_STACK_FIFO_QUEUE_DEFINES_SVH
`define TWO_STACK_FIFO_QUEUE_DEFINES_SVH

// Checked only while out of reset.
`define TSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tsq_pkg.sv
// Shared constants and types for the two-stack queue.
`timescale 1ns / 1ps
package tsq_pkg;

  localparam int STACK_DEPTH = 512;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;

  // Stream beat widths, padded to whole bytes.
  localparam int IN_RAW_W    = CMD_W + DATA_W;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = DATA_W + STAT_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_RAW_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] word_t;

endpackage

FILE: rtl/two_stack_fifo_queue.sv
// Top level of the two-stack FIFO queue: sequencer, count registers, stack RAMs.
// Usage
//   Slave stream in_*: one beat is one command, tdata = {pad, value, command}.
//   Master stream out_*: one beat per command, tdata = {pad, status, front_value}.
//   command 0 pushes value, 1 reads the oldest word, 2 removes it; code 3 is a
//   no-op that answers ok. Status 1 means the inbound stack was full and the push
//   was dropped, status 2 means the queue was empty.
// Command flow
//   One command is in flight at a time; in_tready is low until its result beat
//   has been loaded. Push, remove and no-op pass through one execute state
//   before out_tvalid rises. Read front adds a wait state for the registered
//   outbound RAM read. A read or remove that finds the outbound stack empty
//   first moves the whole inbound stack across, one word at a time (inbound
//   RAM read, then outbound write), and then re-runs the command.
// Reset
//   rst_n is synchronous, active low; both counts go to zero. RAM contents are
//   never cleared: only entries below a count are read. No warm-up pass.
// Backpressure
//   The result sits in an output register until out_tready; a new command is
//   taken in the same cycle the old result leaves.
`timescale 1ns / 1ps
`include "two_stack_fifo_queue_defines.svh"
module two_stack_fifo_queue (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tsq_pkg::IN_TDATA_W-1:0]     in_tdata,   // [1:0] command, [33:2] value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tsq_pkg::OUT_TDATA_W-1:0]    out_tdata   // [31:0] front_value, [33:32] status
);
  import tsq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_XFER_RD,
    S_XFER_WR
  } state_t;

  state_t   state_r;
  cnt_t     in_cnt_r;
  cnt_t     out_cnt_r;
  logic     out_valid_r;
  word_t    front_r;
  status_t  status_r;

  // Latched command beat.
  logic [CMD_W-1:0] cmd_r;
  word_t            value_r;

  logic accept;
  assign accept    = in_tvalid && in_tready;
  // Only one command in flight; output register is free once its beat leaves.
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_tdata[CMD_W-1:0];
      value_r <= in_tdata[IN_RAW_W-1:CMD_W];
    end
  end

  logic in_full, in_empty, out_empty;
  assign in_full   = (in_cnt_r == cnt_t'(STACK_DEPTH));
  assign in_empty  = (in_cnt_r == '0);
  assign out_empty = (out_cnt_r == '0);

  // Shared step unit: which count it works on depends on the state.
  cnt_t step_opnd, step_q;
  logic step_inc;

  always_comb begin
    step_opnd = out_cnt_r;
    step_inc  = 1'b0;
    unique case (state_r)
      S_EXEC: begin
        if (cmd_r == CMD_PUSH) begin
          step_opnd = in_cnt_r;
          step_inc  = 1'b1;
        end
      end
      S_XFER_RD: begin
        step_opnd = in_cnt_r;
      end
      S_XFER_WR: begin
        step_inc = 1'b1;
      end
      default: begin
        step_opnd = out_cnt_r;
      end
    endcase
  end

  tsq_step_unit u_step (
    .opnd   (step_opnd),
    .inc    (step_inc),
    .result (step_q)
  );

  // Stack RAMs.
  logic  in_we, out_we;
  addr_t in_waddr, in_raddr, out_waddr, out_raddr;
  word_t in_rdata, out_rdata;

  assign in_we     = (state_r == S_EXEC) && (cmd_r == CMD_PUSH) && !in_full;
  assign in_waddr  = in_cnt_r[ADDR_W-1:0];
  assign in_raddr  = step_q[ADDR_W-1:0];
  assign out_we    = (state_r == S_XFER_WR);
  assign out_waddr = out_cnt_r[ADDR_W-1:0];
  assign out_raddr = step_q[ADDR_W-1:0];

  tsq_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (value_r),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  tsq_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (in_rdata),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  // Sequencer, counts and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      front_r     <= '0;
      status_r    <= ST_OK;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_r)
            CMD_PUSH: begin
              front_r     <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
              if (in_full) begin
                status_r <= ST_FULL;
              end else begin
                status_r <= ST_OK;
                in_cnt_r <= step_q;
              end
            end
            CMD_READ, CMD_REMOVE: begin
              priority if (out_empty && !in_empty) begin
                state_r <= S_XFER_RD;
              end else if (out_empty) begin
                front_r     <= '0;
                status_r    <= ST_EMPTY;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else if (cmd_r == CMD_READ) begin
                // RAM read issued at out_cnt - 1.
                state_r <= S_RD_WAIT;
              end else begin
                out_cnt_r   <= step_q;
                front_r     <= '0;
                status_r    <= ST_OK;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end
            end
            default: begin
              front_r     <= '0;
              status_r    <= ST_OK;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          endcase
        end
        S_RD_WAIT: begin
          front_r     <= out_rdata;
          status_r    <= ST_OK;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_XFER_RD: begin
          // Pop inbound top; data shows up next cycle.
          in_cnt_r <= step_q;
          state_r  <= S_XFER_WR;
        end
        S_XFER_WR: begin
          out_cnt_r <= step_q;
          if (in_empty) begin
            state_r <= S_EXEC;
          end else begin
            state_r <= S_XFER_RD;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, status_r, front_r};

  // Result register is never busy while a command is being worked on.
  `TSQ_ASSERT_ALWAYS(a_out_free_when_busy, (state_r != S_IDLE) |-> !out_valid_r,
                     "result register busy during command")
  // Counts never exceed the stack depth.
  `TSQ_ASSERT(a_cnt_range,
              (in_cnt_r <= cnt_t'(STACK_DEPTH)) && (out_cnt_r <= cnt_t'(STACK_DEPTH)),
              "stack count out of range")
  // A transfer write never lands past the top of the outbound stack.
  `TSQ_ASSERT(a_xfer_no_overflow,
              (state_r == S_XFER_WR) |-> (out_cnt_r < cnt_t'(STACK_DEPTH)),
              "outbound overflow during transfer")
  // An empty status means both stacks really are empty.
  `TSQ_ASSERT(a_empty_status,
              (out_valid_r && (status_r == ST_EMPTY)) |-> (in_empty && out_empty),
              "empty status with words queued")

endmodule

FILE: rtl/tsq_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps
module tsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/tsq_step_unit.sv
// Shared count step unit: one incrementer/decrementer for both stack counts.
`timescale 1ns / 1ps
module tsq_step_unit (
  input  tsq_pkg::cnt_t opnd,
  input  logic          inc,
  output tsq_pkg::cnt_t result
);
  import tsq_pkg::*;

  always_comb begin
    if (inc) begin
      result = opnd + cnt_t'(1);
    end else begin
      result = opnd - cnt_t'(1);
    end
  end

endmodule
